>>> hw/rtl/h2r_pkg.sv
// Shared constants, types and codes for the HSL to RGB pixel converter.
package h2r_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int HUE_W         = 16;
    localparam int LEVEL_W       = 13;
    localparam int CHAN_W        = 8;
    localparam int QUEUE_DEPTH   = 4;

    // Pi and two pi with 32 fraction bits.
    localparam logic [63:0] PI_Q32     = 64'h0000_0003_243F_6A88;
    localparam logic [63:0] TWO_PI_Q32 = 64'h0000_0006_487E_D511;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef enum logic [1:0] {
        HC_PASS = 2'd0,
        HC_NEG  = 2'd1,
        HC_OVER = 2'd2
    } t_hue_cls;

    typedef struct packed {
        logic avail;
        logic full;
    } t_q_stat;

endpackage

>>> hw/rtl/h2r_front.sv
// Front pipeline: hue wrapping, hue to sector and fraction, level clamping.
module h2r_front import h2r_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [HUE_W-1:0] i_hue_rad,
    input  logic [LEVEL_W-1:0]      i_sat_level,
    input  logic [LEVEL_W-1:0]      i_light_level,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [FRAC_BITS:0]      o_sat,
    output logic [FRAC_BITS:0]      o_light,
    output t_sector                 o_sector,
    output logic [FRAC_BITS:0]      o_dist
);

    localparam int NS  = 6;
    localparam int LW  = FRAC_BITS + 1;
    localparam int CW  = (LEVEL_W > LW) ? LEVEL_W : LW;
    localparam int HW  = FRAC_BITS + 3;
    localparam int AW  = HUE_W + 1;
    localparam int QW  = (AW - FRAC_BITS - 2 > 1) ? AW - FRAC_BITS - 2 : 1;
    localparam int EW  = ((AW > HW + QW) ? AW : HW + QW) + 1;
    localparam int K   = AW + HW;
    localparam int S   = HW + 36;
    localparam int SPL = (S + 1) / 2;
    localparam int MHW = S - SPL;

    localparam logic [63:0] TWO_PI_Q =
        (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] RECIP_T = ((64'd1 << K) + TWO_PI_Q - 64'd1) / TWO_PI_Q;
    localparam logic [127:0] M_FULL =
        ((128'd3 << (32 + S)) + 128'(PI_Q32) - 128'd1) / 128'(PI_Q32);
    localparam logic [SPL-1:0] M_LO   = M_FULL[SPL-1:0];
    localparam logic [MHW-1:0] M_HI   = M_FULL[S-1:SPL];
    localparam logic [HW-1:0]  T_H    = HW'(TWO_PI_Q);
    localparam logic [HW-1:0]  HP_MAX = HW'(64'd6 << FRAC_BITS);
    localparam logic [LW-1:0]  ONE_L  = LW'(64'd1 << FRAC_BITS);
    localparam logic [2:0]     SEC_TOP = SEC_5;

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    logic [AW-1:0]       r_a [2];
    t_hue_cls            r_cls [3];
    logic [HW-1:0]       r_hpass [3];
    logic [QW-1:0]       r_q;
    logic [HW-1:0]       r_rem;
    logic [HW-1:0]       r_hw;
    logic [HW+SPL-1:0]   r_pl;
    logic [HW+MHW-1:0]   r_ph;
    t_sector             r_sec;
    logic [LW-1:0]       r_dist;
    logic [LW-1:0]       r_sat [NS];
    logic [LW-1:0]       r_lgt [NS];

    logic [AW-1:0]       hue_x;
    logic                over;
    logic [CW-1:0]       sat_x;
    logic [CW-1:0]       lgt_x;
    logic [AW-1:0]       n_a;
    t_hue_cls            n_cls;
    logic [HW-1:0]       n_hpass;
    logic [LW-1:0]       n_sat;
    logic [LW-1:0]       n_lgt;
    logic [K+QW-1:0]     q_prod;
    logic [QW-1:0]       n_q;
    logic [EW-1:0]       rem_full;
    logic [HW-1:0]       n_rem;
    logic [HW-1:0]       n_hw;
    logic [HW+SPL-1:0]   n_pl;
    logic [HW+MHW-1:0]   n_ph;
    logic [HW+S-1:0]     hp_sum;
    logic [HW-1:0]       hp;
    logic [HW-1:0]       hp_c;
    logic [2:0]          sec_raw;
    logic [FRAC_BITS:0]  tmod;
    t_sector             n_sec;
    logic [LW-1:0]       n_dist;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        adv[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    // Stage 0: classify the hue and clamp the levels.
    assign hue_x = {i_hue_rad[HUE_W-1], i_hue_rad};
    assign over  = !hue_x[AW-1] && (EW'(hue_x) > EW'(TWO_PI_Q));
    assign sat_x = CW'(i_sat_level);
    assign lgt_x = CW'(i_light_level);
    assign n_sat = (sat_x > CW'(ONE_L)) ? ONE_L : LW'(sat_x);
    assign n_lgt = (lgt_x > CW'(ONE_L)) ? ONE_L : LW'(lgt_x);
    assign n_hpass = HW'(hue_x);

    always_comb begin
        if (hue_x[AW-1]) begin
            n_cls = HC_NEG;
            n_a   = AW'(0) - hue_x;
        end else if (over) begin
            n_cls = HC_OVER;
            n_a   = hue_x - AW'(1);
        end else begin
            n_cls = HC_PASS;
            n_a   = hue_x;
        end
    end

    // Stage 1: quotient by two pi through an exact reciprocal.
    assign q_prod = (K+QW)'(r_a[0]) * (K+QW)'(RECIP_T);
    assign n_q    = q_prod[K+QW-1:K];

    // Stage 2: remainder.
    assign rem_full = EW'(r_a[1]) - EW'(r_q) * EW'(TWO_PI_Q);
    assign n_rem    = rem_full[HW-1:0];

    // Stage 3: negative hues land in [0, 2pi), large ones in (0, 2pi].
    always_comb begin
        unique case (r_cls[2])
            HC_NEG:  n_hw = (r_rem == '0) ? '0 : T_H - r_rem;
            HC_OVER: n_hw = r_rem + HW'(1);
            HC_PASS: n_hw = r_hpass[2];
            default: n_hw = r_hpass[2];
        endcase
    end

    // Stage 4: partial products of hue times 3/pi.
    assign n_pl = (HW+SPL)'(r_hw) * (HW+SPL)'(M_LO);
    assign n_ph = (HW+MHW)'(r_hw) * (HW+MHW)'(M_HI);

    // Stage 5: sector and distance of the scaled hue, taken modulo two, from one.
    assign hp_sum  = ((HW+S)'(r_ph) << SPL) + (HW+S)'(r_pl);
    assign hp      = hp_sum[HW+S-1:S];
    assign hp_c    = (hp > HP_MAX) ? HP_MAX : hp;
    assign sec_raw = hp_c[HW-1:FRAC_BITS];
    assign n_sec   = (sec_raw > SEC_TOP) ? SEC_5 : t_sector'(sec_raw);
    assign tmod    = hp_c[FRAC_BITS:0];
    assign n_dist  = tmod[FRAC_BITS] ? {1'b0, tmod[FRAC_BITS-1:0]}
                                     : ONE_L - {1'b0, tmod[FRAC_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_a[0]     <= n_a;
            r_cls[0]   <= n_cls;
            r_hpass[0] <= n_hpass;
            r_sat[0]   <= n_sat;
            r_lgt[0]   <= n_lgt;
        end
        if (adv[1]) begin
            r_a[1]     <= r_a[0];
            r_q        <= n_q;
            r_cls[1]   <= r_cls[0];
            r_hpass[1] <= r_hpass[0];
        end
        if (adv[2]) begin
            r_rem      <= n_rem;
            r_cls[2]   <= r_cls[1];
            r_hpass[2] <= r_hpass[1];
        end
        if (adv[3]) begin
            r_hw <= n_hw;
        end
        if (adv[4]) begin
            r_pl <= n_pl;
            r_ph <= n_ph;
        end
        if (adv[5]) begin
            r_sec  <= n_sec;
            r_dist <= n_dist;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_sat[k] <= r_sat[k-1];
                r_lgt[k] <= r_lgt[k-1];
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_sat    = r_sat[NS-1];
    assign o_light  = r_lgt[NS-1];
    assign o_sector = r_sec;
    assign o_dist   = r_dist;

endmodule

>>> hw/rtl/h2r_fifo.sv
// Short register queue between the front and back pipelines.
module h2r_fifo import h2r_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;

    logic             full;
    logic             avail;
    logic             push;
    logic             pop;
    logic [PW-1:0]    n_wp;
    logic [PW-1:0]    n_rp;
    logic [CNTW-1:0]  n_cnt;

    assign full  = (r_cnt == CNTW'(DEPTH));
    assign avail = (r_cnt != '0);
    assign push  = i_valid && !full;
    assign pop   = avail && !i_stall;

    assign n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
    assign n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= n_wp;
            end
            if (pop) begin
                r_rp <= n_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.avail = avail;
    assign o_stat.full  = full;

endmodule

>>> hw/rtl/h2r_back.sv
// Back pipeline: chroma, second component, lightness offset and 8-bit channels.
module h2r_back import h2r_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FRAC_BITS:0] i_sat,
    input  logic [FRAC_BITS:0] i_light,
    input  t_sector            i_sector,
    input  logic [FRAC_BITS:0] i_dist,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAN_W-1:0]  o_red_out,
    output logic [CHAN_W-1:0]  o_green_out,
    output logic [CHAN_W-1:0]  o_blue_out
);

    localparam int NS  = 4;
    localparam int LW  = FRAC_BITS + 1;
    localparam int CHW = 2 * FRAC_BITS + 1;
    localparam int VW  = CHW + 1;
    localparam int XW  = CHW + LW;
    localparam logic [LW-1:0] ONE_L = LW'(64'd1 << FRAC_BITS);
    localparam logic [LW:0]   ONE_X = {1'b0, ONE_L};

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    logic [CHW-1:0]          r_chr;
    logic [LW-1:0]           r_w;
    logic [LW-1:0]           r_lgt;
    t_sector                 r_sec [2];
    logic [2*LW-1:0]         r_pxl;
    logic [FRAC_BITS+LW-1:0] r_pxh;
    logic [VW-1:0]           r_c2;
    logic [VW-1:0]           r_m2;
    logic [VW-1:0]           r_sr;
    logic [VW-1:0]           r_sg;
    logic [VW-1:0]           r_sb;
    logic [CHAN_W-1:0]       r_red;
    logic [CHAN_W-1:0]       r_green;
    logic [CHAN_W-1:0]       r_blue;

    logic [LW:0]             two_l;
    logic [LW:0]             l_off;
    logic [LW-1:0]           span;
    logic [2*LW-1:0]         chr_prod;
    logic [CHW-1:0]          n_chr;
    logic [LW-1:0]           n_w;
    logic [2*LW-1:0]         n_pxl;
    logic [FRAC_BITS+LW-1:0] n_pxh;
    logic [VW-1:0]           n_c2;
    logic [VW-1:0]           n_m2;
    logic [XW-1:0]           x_full;
    logic [VW-1:0]           x2;
    logic [VW-1:0]           ch_r;
    logic [VW-1:0]           ch_g;
    logic [VW-1:0]           ch_b;
    logic [VW-1:0]           n_sr;
    logic [VW-1:0]           n_sg;
    logic [VW-1:0]           n_sb;

    // Scale a sum with 2*FRAC_BITS+1 fraction bits by 255 and saturate.
    function automatic logic [CHAN_W-1:0] to_byte(input logic [VW-1:0] v);
        logic [VW+CHAN_W-1:0] p;
        logic [CHAN_W:0]      q;
        p = {v, CHAN_W'(0)} - (VW+CHAN_W)'(v);
        q = p[VW+CHAN_W-1:VW-1];
        to_byte = q[CHAN_W] ? CHAN_MAX : q[CHAN_W-1:0];
    endfunction

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    // Stage 0: chroma = (1 - |2L - 1|) * S, kept exact, and the weight 1 - dist.
    assign two_l    = {i_light, 1'b0};
    assign l_off    = (two_l >= ONE_X) ? two_l - ONE_X : ONE_X - two_l;
    assign span     = ONE_L - l_off[LW-1:0];
    assign chr_prod = (2*LW)'(span) * (2*LW)'(i_sat);
    assign n_chr    = chr_prod[CHW-1:0];
    assign n_w      = ONE_L - i_dist;

    // Stage 1: split product chroma * (1 - dist), doubled chroma and offset m.
    assign n_pxl = (2*LW)'(r_chr[FRAC_BITS:0]) * (2*LW)'(r_w);
    assign n_pxh = (FRAC_BITS+LW)'(r_chr[CHW-1:LW]) * (FRAC_BITS+LW)'(r_w);
    assign n_c2  = {r_chr, 1'b0};
    assign n_m2  = (VW'(r_lgt) << LW) - VW'(r_chr);

    // Stage 2: finish x, route the components by sector and add m.
    assign x_full = (XW'(r_pxh) << LW) + XW'(r_pxl);
    assign x2     = VW'(x_full >> (FRAC_BITS - 1));

    always_comb begin
        unique case (r_sec[1])
            SEC_0: begin ch_r = r_c2; ch_g = x2;   ch_b = '0;   end
            SEC_1: begin ch_r = x2;   ch_g = r_c2; ch_b = '0;   end
            SEC_2: begin ch_r = '0;   ch_g = r_c2; ch_b = x2;   end
            SEC_3: begin ch_r = '0;   ch_g = x2;   ch_b = r_c2; end
            SEC_4: begin ch_r = x2;   ch_g = '0;   ch_b = r_c2; end
            SEC_5: begin ch_r = r_c2; ch_g = '0;   ch_b = x2;   end
            default: begin ch_r = r_c2; ch_g = '0; ch_b = x2;   end
        endcase
    end

    assign n_sr = ch_r + r_m2;
    assign n_sg = ch_g + r_m2;
    assign n_sb = ch_b + r_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_chr    <= n_chr;
            r_w      <= n_w;
            r_lgt    <= i_light;
            r_sec[0] <= i_sector;
        end
        if (adv[1]) begin
            r_pxl    <= n_pxl;
            r_pxh    <= n_pxh;
            r_c2     <= n_c2;
            r_m2     <= n_m2;
            r_sec[1] <= r_sec[0];
        end
        if (adv[2]) begin
            r_sr <= n_sr;
            r_sg <= n_sg;
            r_sb <= n_sb;
        end
        if (adv[3]) begin
            r_red   <= to_byte(r_sr);
            r_green <= to_byte(r_sg);
            r_blue  <= to_byte(r_sb);
        end
    end

    assign o_valid     = r_v[NS-1];
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

>>> hw/rtl/hsl_to_rgb_pixel.sv
// HSL to RGB pixel converter, top level.
// Input channel: i_valid / o_stall with i_hue_rad (signed radians), i_sat_level and
// i_light_level (unsigned, 1.0 at 2^FRAC_BITS). A transaction is taken at a rising
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_red_out, o_green_out, o_blue_out.
// A transaction completes at a rising edge with o_valid high and i_stall low.
// Throughput: one pixel per clock cycle, sustained for as long as the receiver
// keeps i_stall low.
// On its way to the output a pixel passes through six front stages (hue wrap, hue
// scaling, sector split), the queue, and four back stages (chroma, products,
// channel sums, 8-bit scaling).
// When the receiver stalls, the back stages fill first, then the four-entry queue,
// then the front stages; o_stall rises only once all of them are full, and a
// waiting result is held unchanged on the outputs.
// Reset is synchronous and active low; it empties the pipelines and the queue,
// so o_valid is low in the cycle after reset.
module hsl_to_rgb_pixel import h2r_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [HUE_W-1:0] i_hue_rad,
    input  logic [LEVEL_W-1:0]      i_sat_level,
    input  logic [LEVEL_W-1:0]      i_light_level,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CHAN_W-1:0]       o_red_out,
    output logic [CHAN_W-1:0]       o_green_out,
    output logic [CHAN_W-1:0]       o_blue_out
);

    localparam int LW    = FRAC_BITS + 1;
    localparam int SEC_W = $bits(t_sector);
    localparam int QWID  = 3 * LW + SEC_W;

    logic            f_valid;
    logic [LW-1:0]   f_sat;
    logic [LW-1:0]   f_lgt;
    t_sector         f_sec;
    logic [LW-1:0]   f_dist;
    logic [QWID-1:0] q_in;
    logic [QWID-1:0] q_out;
    t_q_stat         q_stat;
    logic            b_stall;
    logic [LW-1:0]   b_sat;
    logic [LW-1:0]   b_lgt;
    logic [LW-1:0]   b_dist;
    logic [SEC_W-1:0] b_sec_bits;

    h2r_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_hue_rad     (i_hue_rad),
        .i_sat_level   (i_sat_level),
        .i_light_level (i_light_level),
        .o_valid       (f_valid),
        .i_stall       (q_stat.full),
        .o_sat         (f_sat),
        .o_light       (f_lgt),
        .o_sector      (f_sec),
        .o_dist        (f_dist)
    );

    assign q_in = {f_sat, f_lgt, f_dist, f_sec};

    h2r_fifo #(
        .WIDTH(QWID),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (q_in),
        .i_stall (b_stall),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    assign {b_sat, b_lgt, b_dist, b_sec_bits} = q_out;

    h2r_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_stat.avail),
        .o_stall     (b_stall),
        .i_sat       (b_sat),
        .i_light     (b_lgt),
        .i_sector    (t_sector'(b_sec_bits)),
        .i_dist      (b_dist),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

`ifndef SYNTHESIS
    // The input side may only be held off once the queue has filled up.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_stat.full)
        else $error("input stalled while the queue has room");

    // A full queue that the back end does not drain stays full.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && b_stall) |=> q_stat.full)
        else $error("queue level changed without a transaction");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented right after reset");
`endif

endmodule

>>> tb/sv/hsl_to_rgb_pixel_test.sv
// Self-checking testbench for the hsl_to_rgb_pixel converter.
`timescale 1ns / 100ps

module hsl_to_rgb_pixel_test;
    import h2r_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [LEVEL_W-1:0]      sat;
        logic [LEVEL_W-1:0]      light;
        logic                    known;
        t_rgb                    rgb;
    } t_pixel_row;

    localparam longint ONE_Q    = longint'(1) << FRAC_BITS_DEF;
    localparam longint TWO_PI_Q =
        (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS_DEF))) >> (32 - FRAC_BITS_DEF);
    localparam int RANDOM_PER_PROFILE = 250;
    localparam int STUCK_LIMIT        = 2000;
    localparam int SETTLE_CYCLES      = 20;
    localparam int DIRECTED_ROWS      = 22;

    localparam t_rgb BLACK    = '{8'd0, 8'd0, 8'd0};
    localparam t_rgb WHITE    = '{CHAN_MAX, CHAN_MAX, CHAN_MAX};
    localparam t_rgb GRAY_MID = '{8'd127, 8'd127, 8'd127};
    localparam t_rgb PURE_RED = '{CHAN_MAX, 8'd0, 8'd0};

    // Rows with known set carry a result that follows directly from the formulas;
    // the rest go through the predictor.
    localparam t_pixel_row DIRECTED [DIRECTED_ROWS] = '{
        '{16'sd0,      13'd0,    13'd0,    1'b1, BLACK},
        '{16'sd0,      13'd4096, 13'd4096, 1'b1, WHITE},
        '{16'sd0,      13'd8191, 13'd8191, 1'b1, WHITE},
        '{16'sd0,      13'd0,    13'd2048, 1'b1, GRAY_MID},
        '{16'sd0,      13'd4096, 13'd2048, 1'b1, PURE_RED},
        '{16'sd0,      13'd8191, 13'd2048, 1'b1, PURE_RED},
        '{-16'sd20000, 13'd8191, 13'd0,    1'b1, BLACK},
        '{16'sh8000,   13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sh7FFF,   13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd25736,  13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd25737,  13'd4096, 13'd2048, 1'b0, BLACK},
        '{-16'sd25736, 13'd4096, 13'd2048, 1'b0, BLACK},
        '{-16'sd1,     13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd1,      13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd2144,   13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd4289,   13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd8579,   13'd4096, 13'd2048, 1'b0, BLACK},
        '{16'sd12868,  13'd4096, 13'd1024, 1'b0, BLACK},
        '{16'sd17157,  13'd3000, 13'd2048, 1'b0, BLACK},
        '{16'sd21447,  13'd4096, 13'd3500, 1'b0, BLACK},
        '{16'sd30000,  13'd1000, 13'd3000, 1'b0, BLACK},
        '{-16'sd9000,  13'd5000, 13'd4095, 1'b0, BLACK}
    };

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic signed [HUE_W-1:0] i_hue_rad     = '0;
    logic [LEVEL_W-1:0]      i_sat_level   = '0;
    logic [LEVEL_W-1:0]      i_light_level = '0;
    logic                    i_stall       = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [CHAN_W-1:0]       o_red_out;
    logic [CHAN_W-1:0]       o_green_out;
    logic [CHAN_W-1:0]       o_blue_out;

    t_rgb pending_rgb[$];
    t_rgb want_rgb;
    int   send_idle_pct   = 38;
    int   recv_idle_pct   = 87;
    int   pixels_sent     = 0;
    int   results_checked = 0;
    int   error_count     = 0;
    int   stuck_cycles    = 0;

    hsl_to_rgb_pixel #(
        .FRAC_BITS(FRAC_BITS_DEF)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue_rad    (i_hue_rad),
        .i_sat_level  (i_sat_level),
        .i_light_level(i_light_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [CHAN_W-1:0] chan_byte(input longint unsigned sum);
        longint unsigned scaled;
        scaled = (sum * 64'd255) >> (2 * FRAC_BITS_DEF + 1);
        return (scaled > 64'd255) ? CHAN_MAX : scaled[CHAN_W-1:0];
    endfunction

    function automatic t_rgb predict_rgb(input logic signed [HUE_W-1:0] hue,
                                         input logic [LEVEL_W-1:0] sat,
                                         input logic [LEVEL_W-1:0] light);
        longint          h, s, l, rem, hp, tmod, dev, chroma, x2, c2, m2, r1, g1, b1;
        longint unsigned scaled_hue;
        t_hue_cls        cls;
        t_sector         sec;
        t_rgb            rgb;
        h = hue;
        s = (longint'(sat) > ONE_Q) ? ONE_Q : longint'(sat);
        l = (longint'(light) > ONE_Q) ? ONE_Q : longint'(light);

        cls = (h < 0) ? HC_NEG : ((h > TWO_PI_Q) ? HC_OVER : HC_PASS);
        case (cls)
            HC_NEG: begin
                rem = (-h) % TWO_PI_Q;
                h   = (rem != 0) ? TWO_PI_Q - rem : 0;
            end
            HC_OVER: begin
                h = ((h - 1) % TWO_PI_Q) + 1;
            end
            default: begin
            end
        endcase

        // Scale by 3/pi, pinned at six; a hue of exactly two pi lands on six, in sector 5.
        scaled_hue = (longint'(unsigned'(h)) * 64'd3) << 32;
        hp = longint'(scaled_hue / PI_Q32);
        if (hp > 6 * ONE_Q) hp = 6 * ONE_Q;
        sec = ((hp >> FRAC_BITS_DEF) > 5) ? SEC_5 : t_sector'(3'(hp >> FRAC_BITS_DEF));
        tmod = hp % (2 * ONE_Q);

        dev = 2 * l - ONE_Q;
        if (dev < 0) dev = -dev;
        chroma = (ONE_Q - dev) * s;
        dev = tmod - ONE_Q;
        if (dev < 0) dev = -dev;
        x2 = (chroma * (ONE_Q - dev)) >>> (FRAC_BITS_DEF - 1);
        c2 = chroma * 2;
        m2 = (l << (FRAC_BITS_DEF + 1)) - chroma;

        case (sec)
            SEC_0:   begin r1 = c2; g1 = x2; b1 = 0;  end
            SEC_1:   begin r1 = x2; g1 = c2; b1 = 0;  end
            SEC_2:   begin r1 = 0;  g1 = c2; b1 = x2; end
            SEC_3:   begin r1 = 0;  g1 = x2; b1 = c2; end
            SEC_4:   begin r1 = x2; g1 = 0;  b1 = c2; end
            default: begin r1 = c2; g1 = 0;  b1 = x2; end
        endcase
        rgb.red   = chan_byte(longint'(unsigned'(r1 + m2)));
        rgb.green = chan_byte(longint'(unsigned'(g1 + m2)));
        rgb.blue  = chan_byte(longint'(unsigned'(b1 + m2)));
        return rgb;
    endfunction

    task automatic report_mismatch(input string detail);
        $display("ERROR at %0t: result %0d: %s", $realtime, results_checked, detail);
        error_count++;
    endtask

    // Presents one pixel, holds it through any stall and queues its expected colour
    // at the edge where the transaction is taken.
    task automatic send_pixel(input logic signed [HUE_W-1:0] hue,
                              input logic [LEVEL_W-1:0] sat,
                              input logic [LEVEL_W-1:0] light,
                              input t_rgb want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_hue_rad     <= hue;
        i_sat_level   <= sat;
        i_light_level <= light;
        do @(posedge i_clk); while (o_stall);
        pending_rgb.push_back(want);
        pixels_sent++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                if (pending_rgb.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction rgb=%0d,%0d,%0d",
                                              o_red_out, o_green_out, o_blue_out));
                end else begin
                    want_rgb = pending_rgb.pop_front();
                    if (o_red_out !== want_rgb.red)
                        report_mismatch($sformatf("red got %0d, expected %0d",
                                                  o_red_out, want_rgb.red));
                    if (o_green_out !== want_rgb.green)
                        report_mismatch($sformatf("green got %0d, expected %0d",
                                                  o_green_out, want_rgb.green));
                    if (o_blue_out !== want_rgb.blue)
                        report_mismatch($sformatf("blue got %0d, expected %0d",
                                                  o_blue_out, want_rgb.blue));
                    results_checked++;
                end
            end
        end
    end

    // Any cycle without a transaction on either side counts toward the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
                $display("hsl_to_rgb_pixel verification failed");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        logic signed [HUE_W-1:0] hue_v;
        logic [LEVEL_W-1:0]      sat_v;
        logic [LEVEL_W-1:0]      light_v;
        t_pixel_row              row;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[idx]) begin
            row = DIRECTED[idx];
            send_pixel(row.hue, row.sat, row.light,
                       row.known ? row.rgb : predict_rgb(row.hue, row.sat, row.light));
        end

        for (int profile = 0; profile < 3; profile++) begin
            send_idle_pct = (profile == 0) ? 38 : ((profile == 1) ? 87 : 0);
            recv_idle_pct = (profile == 0) ? 87 : ((profile == 1) ? 38 : 0);
            for (int n = 0; n < RANDOM_PER_PROFILE; n++) begin
                case ($urandom_range(3))
                    0: hue_v = HUE_W'($urandom_range(16'hFFFF));
                    1: hue_v = HUE_W'($urandom_range(TWO_PI_Q));
                    // Close to a sector boundary, including zero and two pi.
                    2: hue_v = HUE_W'(($urandom_range(6) * 42893) / 10
                                      + $urandom_range(8) - 4);
                    default: hue_v = HUE_W'($urandom_range(16'hFFFF));
                endcase
                sat_v   = LEVEL_W'(($urandom_range(9) < 8) ? $urandom_range(ONE_Q)
                                                           : $urandom_range(13'h1FFF));
                light_v = LEVEL_W'(($urandom_range(9) < 8) ? $urandom_range(ONE_Q)
                                                           : $urandom_range(13'h1FFF));
                send_pixel(hue_v, sat_v, light_v, predict_rgb(hue_v, sat_v, light_v));
            end
            // Hold off the sender until the pipeline has drained completely.
            i_valid <= 1'b0;
            while (pending_rgb.size() != 0) @(posedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixels (%0d directed) under three idle profiles;",
                 pixels_sent, DIRECTED_ROWS);
        $display("checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && pending_rgb.size() == 0) begin
            $display("hsl_to_rgb_pixel verification clean");
        end else begin
            $display("hsl_to_rgb_pixel verification failed");
        end
        $finish;
    end

endmodule

>>> hsl_to_rgb_pixel.f
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_front.sv
hw/rtl/h2r_fifo.sv
hw/rtl/h2r_back.sv
hw/rtl/hsl_to_rgb_pixel.sv
tb/sv/hsl_to_rgb_pixel_test.sv
